FILE: sv/omm_pkg.sv
`default_nettype none

package omm_pkg;

    localparam int OPCODE_W = 2;
    localparam int SYM_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int CFG_W    = 7;
    localparam int FIELD_W  = 21;
    localparam int CNT_W    = 2;

    localparam logic [FIELD_W-1:0] COUNT_MAX = {FIELD_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [SYM_W-1:0] sym_t;

    // Mismatch count saturates here: two or more mismatches mean no match
    localparam count_t CNT_SAT = 2'd2;

    typedef struct packed {
        logic              text_en;
        logic              clear;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        sym_t              sym;
    } cell_ctrl_t;

    typedef struct packed {
        logic               found;
        logic               exact;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/omm_ifs.sv
`default_nettype none

interface omm_in_if;
    import omm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SYM_W-1:0]    symbol;
    logic [SLOT_W-1:0]   pattern_index;

    modport source (output valid, output opcode, output symbol, output pattern_index,
                    input ready);
    modport sink   (input valid, input opcode, input symbol, input pattern_index,
                    output ready);
endinterface

interface omm_out_if;
    import omm_pkg::*;

    logic               valid;
    logic               ready;
    logic               match_found;
    logic               exact_match;
    logic [FIELD_W-1:0] start_position;
    logic [FIELD_W-1:0] match_count;

    modport source (output valid, output match_found, output exact_match,
                    output start_position, output match_count, input ready);
    modport sink   (input valid, input match_found, input exact_match,
                    input start_position, input match_count, output ready);
endinterface

`default_nettype wire

FILE: sv/one_mismatch_pattern_matcher.sv
`default_nettype none

// Channel   Dir  Payload                                                   Handshake
// in_ch     in   opcode, symbol, pattern_index                             valid/ready
// out_ch    out  match_found, exact_match, start_position, match_count     valid/ready
// cfg       in   cfg_write_data (pattern_length)                           cfg_write_en
//
// One transaction in per cycle unless the buffer is full; one registered result each.
// Each text symbol advances every cell of the chain in that same cycle; the tap at
// the cell for the current pattern length yields the completed alignment.
// Reset clears the cell counts, text position and match count; pattern symbols
// are undefined until written.
// A two-entry output buffer keeps input ready while one result waits downstream.

module one_mismatch_pattern_matcher #(
    parameter int PATTERN_MAX = 64,
    parameter int TEXT_MAX    = 1048576
) (
    input  wire                         clk,
    input  wire                         rst_n,
    omm_in_if.sink                      in_ch,
    omm_out_if.source                   out_ch,
    input  wire                         cfg_write_en,
    input  wire [omm_pkg::CFG_W-1:0]    cfg_write_data
);
    import omm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int SUM_W = (POS_W + 1 > FIELD_W) ? POS_W + 1 : FIELD_W;

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [CMP_W-1:0]   cfg_ext;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [FIELD_W-1:0] total_reg;
    logic [FIELD_W-1:0] total_next;

    logic               accept;
    logic               can_accept;
    opcode_t            op;
    cell_ctrl_t         ctrl;
    count_t             link [PATTERN_MAX+1];
    count_t             tap  [PATTERN_MAX];
    count_t             done;
    logic [SUM_W-1:0]   end_pos;
    logic [SUM_W-1:0]   start_full;
    logic               hit;
    result_t            res;

    assign in_ch.ready = can_accept;
    assign accept      = in_ch.valid && can_accept;
    assign op          = opcode_t'(in_ch.opcode);

    // Clamp the length register into 1..PATTERN_MAX when it is written
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_write_data);
        if (cfg_ext == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (cfg_ext > CMP_W'(PATTERN_MAX))
        begin
            len_next = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_next = LEN_W'(cfg_ext);
        end
    end

    always_comb
    begin
        ctrl.text_en = accept && (op == OP_TEXT) && (pos_reg < POS_W'(TEXT_MAX));
        ctrl.clear   = accept && (op == OP_RESTART);
        ctrl.wr_en   = accept && (op == OP_PATTERN);
        ctrl.wr_idx  = in_ch.pattern_index;
        ctrl.sym     = in_ch.symbol;
    end

    assign link[0] = '0;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        omm_cell #(
            .CELL_IDX (j),
            .LEN_W    (LEN_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .prev_cnt (link[j]),
            .len      (len_reg),
            .bump_cnt (link[j+1]),
            .tap_cnt  (tap[j])
        );
    end

    // Only the tapped cell drives a nonzero count
    always_comb
    begin
        done = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            done = done | tap[k];
        end
    end

    always_comb
    begin
        end_pos    = SUM_W'(pos_reg) + SUM_W'(1);
        start_full = end_pos - SUM_W'(len_reg) + SUM_W'(1);
        hit        = ctrl.text_en && (end_pos >= SUM_W'(len_reg)) && (done != CNT_SAT);
    end

    always_comb
    begin
        pos_next   = pos_reg;
        total_next = total_reg;
        if (ctrl.clear)
        begin
            pos_next   = '0;
            total_next = '0;
        end
        else if (ctrl.text_en)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (hit && (total_reg != COUNT_MAX))
            begin
                total_next = total_reg + FIELD_W'(1);
            end
        end
    end

    always_comb
    begin
        res.found = hit;
        res.exact = hit && (done == '0);
        res.start = hit ? start_full[FIELD_W-1:0] : '0;
        res.count = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_W'(1);
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                len_reg <= len_next;
            end
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

    omm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .res        (res),
        .can_accept (can_accept),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

FILE: sv/omm_cell.sv
`default_nettype none

module omm_cell #(
    parameter int CELL_IDX = 0,
    parameter int LEN_W    = 7
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  omm_pkg::cell_ctrl_t  ctrl,
    input  omm_pkg::count_t      prev_cnt,
    input  wire [LEN_W-1:0]      len,
    output omm_pkg::count_t      bump_cnt,
    output omm_pkg::count_t      tap_cnt
);
    import omm_pkg::*;

    count_t          cnt_reg;
    count_t          cnt_next;
    sym_t            sym_reg;
    logic [CNT_W:0]  sum;
    logic            write_hit;
    logic            is_tap;

    assign write_hit = ctrl.wr_en && (32'(ctrl.wr_idx) == CELL_IDX);
    assign is_tap    = (len == LEN_W'(CELL_IDX + 1));

    // Count this alignment's mismatch against the pattern symbol held here
    always_comb
    begin
        sum = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, (ctrl.sym != sym_reg)};
        if (sum > {1'b0, CNT_SAT})
        begin
            bump_cnt = CNT_SAT;
        end
        else
        begin
            bump_cnt = sum[CNT_W-1:0];
        end
    end

    assign tap_cnt = is_tap ? bump_cnt : '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.text_en)
        begin
            cnt_next = prev_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_hit)
        begin
            sym_reg <= ctrl.sym;
        end
    end

endmodule

`default_nettype wire

FILE: sv/omm_out_buf.sv
`default_nettype none

module omm_out_buf (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  omm_pkg::result_t   res,
    output logic               can_accept,
    omm_out_if.source          out_ch
);
    import omm_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_free;

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign can_accept = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // Advance the held transaction, park the new one behind it
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = res;
            end
            else
            begin
                out_valid_next = push;
                out_next       = res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.match_found    = out_reg.found;
    assign out_ch.exact_match    = out_reg.exact;
    assign out_ch.start_position = out_reg.start;
    assign out_ch.match_count    = out_reg.count;

endmodule

`default_nettype wire

FILE: bench/omm_match_checker.sv
`default_nettype none

module omm_match_checker #(
    parameter int PATTERN_MAX = 64,
    parameter int TEXT_MAX    = 1048576
) (
    input  wire                         clk,
    input  wire                         rst_n,
    omm_in_if                           in_ch,
    omm_out_if                          out_ch,
    input  wire                         cfg_write_en,
    input  wire [omm_pkg::CFG_W-1:0]    cfg_write_data,
    output int                          failures,
    output int                          pending
);
    import omm_pkg::*;

    sym_t               pattern_copy [PATTERN_MAX];
    count_t             align_miss   [PATTERN_MAX];
    logic [FIELD_W-1:0] text_pos;
    logic [FIELD_W-1:0] match_total;
    logic [CFG_W-1:0]   length_reg;
    result_t            expected_matches [$];

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    function automatic count_t add_mismatch(input count_t c, input sym_t a, input sym_t b);
        if (a != b && c < CNT_SAT)
            return count_t'(c + 1'b1);
        return c;
    endfunction

    task automatic predict_match(input logic [OPCODE_W-1:0] op, input sym_t s,
                                 input logic [SLOT_W-1:0] slot, output result_t r);
        int     span;
        int     j;
        count_t tail;
        r = '0;
        case (op)
            OP_PATTERN:
            begin
                if (int'(slot) < PATTERN_MAX)
                    pattern_copy[slot] = s;
            end
            OP_RESTART:
            begin
                for (j = 0; j < PATTERN_MAX; j++)
                    align_miss[j] = '0;
                text_pos    = '0;
                match_total = '0;
            end
            OP_TEXT:
            begin
                if (int'(text_pos) < TEXT_MAX)
                begin
                    // clamp the register: 0 acts as 1, anything past the chain as full length
                    span = (length_reg == '0) ? 1 :
                           (int'(length_reg) > PATTERN_MAX ? PATTERN_MAX : int'(length_reg));
                    tail = add_mismatch(align_miss[span-1], s, pattern_copy[span-1]);
                    for (j = PATTERN_MAX - 1; j >= 1; j--)
                        align_miss[j] = add_mismatch(align_miss[j-1], s, pattern_copy[j-1]);
                    align_miss[0] = '0;
                    text_pos = text_pos + 1'b1;
                    if (int'(text_pos) >= span && tail < CNT_SAT)
                    begin
                        r.found = 1'b1;
                        r.exact = (tail == '0);
                        r.start = text_pos - FIELD_W'(span) + 1'b1;
                        if (match_total != COUNT_MAX)
                            match_total = match_total + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.count = match_total;
    endtask

    task automatic report_field(input string field, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= 100)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        int      k;
        if (!rst_n)
        begin
            for (k = 0; k < PATTERN_MAX; k++)
            begin
                pattern_copy[k] = '0;
                align_miss[k]   = '0;
            end
            text_pos    = '0;
            match_total = '0;
            length_reg  = CFG_W'(1);
            expected_matches.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_write_en)
                length_reg = cfg_write_data;
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (expected_matches.size() == 0)
                begin
                    failures++;
                    if (failures <= 100)
                        $display({"%0t: result mismatch: expected none, ",
                                  "actual found=%0b exact=%0b start=%0d count=%0d"},
                                 $time, out_ch.match_found, out_ch.exact_match,
                                 out_ch.start_position, out_ch.match_count);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    report_field("match_found", FIELD_W'(want.found), FIELD_W'(out_ch.match_found));
                    report_field("exact_match", FIELD_W'(want.exact), FIELD_W'(out_ch.exact_match));
                    report_field("start_position", want.start, out_ch.start_position);
                    report_field("match_count", want.count, out_ch.match_count);
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                predict_match(in_ch.opcode, in_ch.symbol, in_ch.pattern_index, want);
                // append at the tail of the queue
                expected_matches = {expected_matches, want};
            end
            pending = expected_matches.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
    import omm_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1560;
    localparam int SLOTS        = 64;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             cfg_write_en   = 1'b0;
    logic [CFG_W-1:0] cfg_write_data = '0;
    int               failures;
    int               pending;
    int               cycle_count    = 0;
    int               item_count     = 0;
    bit               no_gaps        = 1'b0;
    int               active_len     = 1;
    bit               narrow_alphabet = 1'b0;
    sym_t             alphabet_base  = '0;
    sym_t             pattern_mirror [SLOTS];

    omm_in_if  in_ch ();
    omm_out_if out_ch ();

    one_mismatch_pattern_matcher uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    omm_match_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .failures       (failures),
        .pending        (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic [OPCODE_W-1:0] op, input sym_t s,
                             input logic [SLOT_W-1:0] slot);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.symbol        <= s;
        in_ch.pattern_index <= slot;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        if (op == OP_PATTERN)
            pattern_mirror[slot] = s;
        item_count++;
    endtask

    // Drain every outstanding result, then write the length register
    task automatic write_length(input logic [CFG_W-1:0] value);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        active_len = (value == '0) ? 1 : (int'(value) > SLOTS ? SLOTS : int'(value));
    endtask

    function automatic sym_t pick_symbol();
        if (narrow_alphabet)
            return alphabet_base ^ sym_t'($urandom_range(0, 1));
        return sym_t'($urandom_range(0, 255));
    endfunction

    // Replay the stored pattern as text, corrupting up to two positions
    task automatic send_alignment(input int misses);
        int   first;
        int   second;
        int   i;
        sym_t s;
        first  = $urandom_range(0, active_len - 1);
        second = $urandom_range(0, active_len - 1);
        for (i = 0; i < active_len; i++)
        begin
            s = pattern_mirror[i];
            if ((misses >= 1 && i == first) || (misses >= 2 && i == second))
                s = s ^ sym_t'($urandom_range(1, 255));
            send_item(OP_TEXT, s, SLOT_W'($urandom_range(0, 63)));
        end
    endtask

    initial
    begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        int i;
        int phase;
        int quota;
        int roll;
        int first_random;
        int next_len;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_PATTERN;
        in_ch.symbol        = '0;
        in_ch.pattern_index = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_length(CFG_W'(3));
        // fill every slot so no comparison ever sees an unwritten symbol
        for (i = 0; i < SLOTS; i++)
            send_item(OP_PATTERN, sym_t'(i * 37 + 11), SLOT_W'(i));

        send_item(OP_PATTERN, 8'h00, 6'd0);
        send_item(OP_PATTERN, 8'hFF, 6'd1);
        send_item(OP_PATTERN, 8'hA5, 6'd2);
        send_item(OP_PATTERN, 8'hFF, 6'd63);
        send_item(OP_TEXT, 8'hA5, 6'd0);
        send_item(OP_RESTART, 8'h00, 6'd0);
        send_item(OP_TEXT, 8'h00, 6'd0);
        send_item(OP_TEXT, 8'hFF, 6'd0);
        send_item(OP_TEXT, 8'hA5, 6'd0);
        send_item(OP_TEXT, 8'h00, 6'd0);
        send_item(OP_TEXT, 8'hFF, 6'd0);
        send_item(OP_TEXT, 8'h00, 6'd0);
        send_item(OP_UNUSED, 8'hFF, 6'd63);
        send_item(OP_PATTERN, 8'h00, 6'd2);
        send_item(OP_TEXT, 8'h00, 6'd0);
        send_item(OP_TEXT, 8'hFF, 6'd0);
        send_item(OP_TEXT, 8'h00, 6'd0);
        send_item(OP_RESTART, 8'hFF, 6'd63);
        send_item(OP_TEXT, 8'h00, 6'd0);
        send_item(OP_TEXT, 8'hFF, 6'd0);

        first_random = item_count;
        phase = 0;
        while (item_count - first_random < RANDOM_ITEMS)
        begin
            case (phase)
                0: next_len = 64;
                1: next_len = 0;
                2: next_len = 127;
                3: next_len = 2;
                4: next_len = 65;
                5: next_len = 1;
                default: next_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, 12);
            endcase
            write_length(CFG_W'(next_len));
            no_gaps = ($urandom_range(0, 3) == 0);
            // skip the restart now and then so the new length meets text in flight
            if ($urandom_range(0, 2) != 0)
                send_item(OP_RESTART, pick_symbol(), SLOT_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 1) == 1)
            begin
                narrow_alphabet = $urandom_range(0, 1);
                alphabet_base   = sym_t'($urandom_range(0, 255));
                for (i = 0; i < active_len; i++)
                    send_item(OP_PATTERN, pick_symbol(), SLOT_W'(i));
            end
            quota = item_count + 120 + $urandom_range(0, 80);
            while (item_count < quota && item_count - first_random < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 65)
                    send_alignment(roll % 3);
                else if (roll < 82)
                    repeat ($urandom_range(1, 8))
                        send_item(OP_TEXT, pick_symbol(), SLOT_W'($urandom_range(0, 63)));
                else if (roll < 90)
                    send_item(OP_PATTERN, pick_symbol(),
                              SLOT_W'($urandom_range(0, active_len - 1)));
                else if (roll < 95)
                    send_item(OP_RESTART, pick_symbol(), SLOT_W'($urandom_range(0, 63)));
                else
                    send_item(OP_UNUSED, pick_symbol(), SLOT_W'($urandom_range(0, 63)));
            end
            phase++;
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
